// ----- design/pd_pkg.sv -----
// Shared types, character codes and hex helpers for the percent decoder.
// No dependencies; every module of the block imports this package.
package pd_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } pd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } pd_out_t;

  // Up to three result bytes caused by one input byte.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            last;
  } pd_job_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b inside {[8'h30:8'h39]}) begin
      v = b - 8'h30;
    end else if (b inside {[8'h41:8'h46]}) begin
      v = b - 8'h37;
    end else if (b inside {[8'h61:8'h66]}) begin
      v = b - 8'h57;
    end
    hex_nib = v[3:0];
  endfunction

endpackage

// ----- design/pd_front.sv -----
// Front end: accepts raw bytes, tracks the escape state and builds result jobs.
// Depends on pd_pkg.
module pd_front import pd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data,
  input  logic    in_valid,
  output logic    in_stall,
  input  pd_in_t  in_data,
  input  logic    q_full,
  output logic    q_push,
  output pd_job_t q_job
);

  logic       plus_as_space;
  logic [1:0] phase;
  logic [7:0] held;
  logic [1:0] phase_next;
  logic [7:0] held_next;
  logic       accept;
  logic       hex;
  logic [7:0] b;
  logic       last;
  logic       fresh_emit;
  logic       fresh_open;
  logic [7:0] fresh_byte;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign b         = in_data.in_byte;
  assign last      = in_data.in_last;
  assign hex       = is_hex(b);

  // Handling of a byte with no escape pending.
  always_comb begin
    fresh_emit = 1'b1;
    fresh_open = 1'b0;
    fresh_byte = b;
    if (plus_as_space && b == PLUS_CHAR) begin
      fresh_byte = SPACE_CHAR;
    end else if (b == PCT_CHAR && !last) begin
      fresh_emit = 1'b0;
      fresh_open = 1'b1;
    end
  end

  always_comb begin
    q_job      = '0;
    q_job.last = last;
    phase_next = PH_NONE;
    held_next  = held;
    case (phase)
      PH_PCT: begin
        if (hex) begin
          if (last) begin
            q_job.bytes[0] = PCT_CHAR;
            q_job.bytes[1] = b;
            q_job.count    = 2'd2;
          end else begin
            held_next  = b;
            phase_next = PH_DIGIT;
          end
        end else begin
          q_job.bytes[0] = PCT_CHAR;
          q_job.bytes[1] = fresh_byte;
          q_job.count    = 2'd1 + {1'b0, fresh_emit};
          phase_next     = fresh_open ? PH_PCT : PH_NONE;
        end
      end
      PH_DIGIT: begin
        if (hex) begin
          q_job.bytes[0] = {hex_nib(held), hex_nib(b)};
          q_job.count    = 2'd1;
        end else begin
          q_job.bytes[0] = PCT_CHAR;
          q_job.bytes[1] = held;
          q_job.bytes[2] = fresh_byte;
          q_job.count    = 2'd2 + {1'b0, fresh_emit};
          phase_next     = fresh_open ? PH_PCT : PH_NONE;
        end
      end
      default: begin
        q_job.bytes[0] = fresh_byte;
        q_job.count    = {1'b0, fresh_emit};
        phase_next     = fresh_open ? PH_PCT : PH_NONE;
      end
    endcase
    if (last) begin
      phase_next = PH_NONE;
      held_next  = 8'd0;
    end
  end

  // A byte that only opens or extends an escape produces no job.
  assign q_push = accept && (q_job.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_as_space <= 1'b0;
      phase         <= PH_NONE;
      held          <= 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        plus_as_space <= cfg_data;
      end
      if (accept) begin
        phase <= phase_next;
        held  <= held_next;
      end
    end
  end

endmodule

// ----- design/pd_queue.sv -----
// Short job queue between the front end and the output serializer.
// Depends on pd_pkg for the job type and depth.
module pd_queue import pd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  pd_job_t push_job,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output pd_job_t head
);

  pd_job_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;

  assign full  = (fill == (QAW+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (QAW+1)'(push && !full) - (QAW+1)'(pop && !empty);
    end
  end

endmodule

// ----- design/pd_back.sv -----
// Back end: walks the head job one byte per cycle into the output register, unless stalled.
// Depends on pd_pkg.
module pd_back import pd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  pd_job_t q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output pd_out_t out_data
);

  logic [1:0] idx;
  logic       advance;
  logic       take;
  logic       final_one;

  assign advance   = !out_valid || !out_stall;
  assign take      = advance && !q_empty;
  assign final_one = (idx == q_head.count - 2'd1);
  assign q_pop     = take && final_one;

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.out_byte   <= q_head.bytes[idx];
      out_data.run_last   <= final_one;
      out_data.string_end <= final_one && q_head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (advance) begin
        out_valid <= !q_empty;
      end
      if (take) begin
        idx <= final_one ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

// ----- design/percent_decode_stream.sv -----
// Streaming URL percent decoder. Each accepted byte's results go as one job into
// the job queue and from there, one at a time, into the output register; one result
// leaves per cycle while out_stall is low, and the output serializer sends the k
// results of one byte in turn. Bytes that only open an escape cause no result.
// Synchronous active-high reset empties the job queue and output register,
// clears the escape state and sets plus_as_space to 0. Depends on pd_pkg.
module percent_decode_stream import pd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data,
  input  logic    in_valid,
  output logic    in_stall,
  input  pd_in_t  in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output pd_out_t out_data
);

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_empty;
  pd_job_t q_job;
  pd_job_t q_head;

  pd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  pd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  pd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- test/percent_decode_stream_tb.sv -----
// Self-checking testbench for percent_decode_stream: directed strings, then random
// strings, most under random idling, and one long output hold-off, checked by a scoreboard.
// Depends on pd_pkg and the percent_decode_stream RTL.
module percent_decode_stream_tb import pd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 80;
  localparam int PHASE_ITEMS    = 80;

  // Predicts the decoded bytes of each accepted input transfer and checks results.
  class decode_scoreboard;
    bit         plus_as_space;
    logic [1:0] esc_phase;
    logic [7:0] held_digit;
    logic [7:0] emit_buf [3];
    int         emit_cnt;
    pd_out_t    expected_q [$];
    int         mismatches;

    function new();
      plus_as_space = 1'b0;
      esc_phase     = PH_NONE;
      held_digit    = 8'd0;
      emit_cnt      = 0;
      mismatches    = 0;
    endfunction

    // Bit 4 set means the byte is not a hex digit; otherwise bits 3:0 hold its value.
    static function logic [4:0] hex_code(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
      if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h41 + 8'd10)};
      if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h61 + 8'd10)};
      return 5'h10;
    endfunction

    function void set_plus(input logic v);
      plus_as_space = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_byte(input logic [7:0] b);
      if (emit_cnt < 3) begin
        emit_buf[emit_cnt] = b;
        emit_cnt++;
      end
    endfunction

    function void fresh_byte(input logic [7:0] b, input logic last);
      if (plus_as_space && b == PLUS_CHAR) begin
        add_byte(SPACE_CHAR);
      end else if (b == PCT_CHAR) begin
        if (last) add_byte(b);
        else esc_phase = PH_PCT;
      end else begin
        add_byte(b);
      end
    endfunction

    function void note_input(input pd_in_t item);
      logic [1:0] ph;
      logic [4:0] cur;
      logic [4:0] first;
      pd_out_t    r;
      ph        = esc_phase;
      cur       = hex_code(item.in_byte);
      emit_cnt  = 0;
      esc_phase = PH_NONE;
      if (ph == PH_PCT) begin
        if (!cur[4]) begin
          if (item.in_last) begin
            add_byte(PCT_CHAR);
            add_byte(item.in_byte);
          end else begin
            held_digit = item.in_byte;
            esc_phase  = PH_DIGIT;
          end
        end else begin
          add_byte(PCT_CHAR);
          fresh_byte(item.in_byte, item.in_last);
        end
      end else if (ph == PH_DIGIT) begin
        if (!cur[4]) begin
          first = hex_code(held_digit);
          add_byte({first[3:0], cur[3:0]});
        end else begin
          add_byte(PCT_CHAR);
          add_byte(held_digit);
          fresh_byte(item.in_byte, item.in_last);
        end
      end else begin
        // Phase code three cannot arise and counts as no escape pending.
        fresh_byte(item.in_byte, item.in_last);
      end
      if (item.in_last) begin
        esc_phase  = PH_NONE;
        held_digit = 8'd0;
      end
      for (int k = 0; k < emit_cnt; k++) begin
        r.out_byte   = emit_buf[k];
        r.run_last   = (k == emit_cnt - 1);
        r.string_end = r.run_last && item.in_last;
        expected_q.insert(expected_q.size(), r);
      end
    endfunction

    function void check_result(input pd_out_t got);
      pd_out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %h run_last %b string_end %b",
                   got.out_byte, got.run_last, got.string_end);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
          got.string_end !== want.string_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected byte %h run_last %b string_end %b, got %h %b %b",
                   want.out_byte, want.run_last, want.string_end,
                   got.out_byte, got.run_last, got.string_end);
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    cfg_valid;
  logic    cfg_ready;
  logic    cfg_data;
  logic    in_valid;
  logic    in_stall;
  pd_in_t  in_data;
  logic    out_valid;
  logic    out_stall;
  pd_out_t out_data;

  decode_scoreboard sb = new();
  logic [7:0] str_buf [$];
  bit quiet    = 1'b0;
  int hold_len = 0;
  int idle_cycles = 0;

  percent_decode_stream dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Monitor and watchdog: every transfer is seen here at the clock edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_plus(cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: short random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    out_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    pd_in_t item;
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.in_byte = b;
    item.in_last = last;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_buf();
    for (int i = 0; i < str_buf.size(); i++) send_byte(str_buf[i], i == str_buf.size() - 1);
  endtask

  task automatic write_plus(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Bytes that only open an escape give no result, so wait a little past the last one.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void put_char(input logic [7:0] c);
    str_buf.insert(str_buf.size(), c);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 5));
      default: return 8'h61 + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    logic [4:0] code;
    do begin
      c    = 8'($urandom_range(0, 255));
      code = decode_scoreboard::hex_code(c);
    end while (!code[4]);
    return c;
  endfunction

  // Printable characters, plus signs and well-formed escapes, with broken escapes and raw bytes mixed in.
  task automatic build_random_string();
    int target;
    int kind;
    str_buf.delete();
    target = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
    while (str_buf.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        put_char(8'($urandom_range(8'h20, 8'h7e)));
      end else if (kind < 45) begin
        put_char(PLUS_CHAR);
      end else if (kind < 70) begin
        put_char(PCT_CHAR);
        put_char(rand_hex_char());
        put_char(rand_hex_char());
      end else if (kind < 82) begin
        put_char(PCT_CHAR);
        if ($urandom_range(0, 1)) put_char(rand_hex_char());
        case ($urandom_range(0, 3))
          0:       put_char(PCT_CHAR);
          1:       put_char(PLUS_CHAR);
          default: put_char(rand_non_hex());
        endcase
      end else if (kind < 90) begin
        put_char(PCT_CHAR);
        if ($urandom_range(0, 1)) put_char(rand_hex_char());
      end else begin
        put_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic plus_seq [5];
    int count;
    plus_seq = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed strings with plus decoding off (reset value).
    send_byte("%", 1'b0); send_byte("e", 1'b0); send_byte("9", 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b0); send_byte("+", 1'b1);
    send_byte("%", 1'b1);
    send_byte("%", 1'b0); send_byte("4", 1'b0); send_byte("G", 1'b1);
    send_byte("%", 1'b0); send_byte("g", 1'b1);
    wait_drain();
    write_plus(1'b1);
    // Plus as space, an escaped plus, and a percent before a plus at the end.
    send_byte("+", 1'b0); send_byte("%", 1'b0); send_byte("2", 1'b0);
    send_byte("B", 1'b0); send_byte("%", 1'b0); send_byte("+", 1'b1);
    // A percent held with one digit, then another percent closing the string.
    send_byte("%", 1'b0); send_byte("a", 1'b0); send_byte("%", 1'b1);
    // A broken escape whose second percent opens a new one.
    send_byte("%", 1'b0); send_byte("%", 1'b0); send_byte("6", 1'b0);
    send_byte("1", 1'b1);

    for (int p = 0; p < 5; p++) begin
      wait_drain();
      write_plus(plus_seq[p]);
      if (p == 4) quiet = 1'b1;
      if (p == 2) hold_len = HOLD_CYCLES;
      count = 0;
      while (count < PHASE_ITEMS) begin
        build_random_string();
        send_buf();
        count += str_buf.size();
      end
    end

    wait_drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
